// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold whenever reset is released
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// types and constants for the strongly connected components block
// ----------------------------------------------------------------------------
package scc_pkg;
    localparam int MaxVertices = 64;
    localparam int VW = $clog2(MaxVertices);
    localparam int NW = VW + 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [5:0]             row_index;
        logic [63:0]            row_bits;
    } t_in;

    typedef struct packed {
        logic [5:0] vertex;
        logic [5:0] component_index;
        logic       last_of_component;
        logic       last_of_run;
    } t_out;

    // per vertex record: discovery number, low-link, on-stack mark
    typedef struct packed {
        logic [6:0] disc;
        logic [6:0] low;
        logic       onstk;
    } t_vrec;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_ROOT, S_ROOT_RD, S_ENTER, S_TOP, S_TOP_WAIT,
        S_SCAN, S_NB_WAIT, S_NB, S_CLOSE, S_POP_RD, S_POP_WAIT, S_POP,
        S_EMIT, S_RET, S_PAR_WAIT, S_PAR, S_FINISH
    } t_state;
endpackage

// ===== hw/rtl/scc_ram.sv =====
// ----------------------------------------------------------------------------
// scc_ram
// generic single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/strongly_connected_components_top.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_components_top
// tarjan component search over a graph held in on-chip memories
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready, payload i_in): op 0 loads one
// adjacency row into the adjacency memory; rows can follow back to back.
// op 1 starts the search, and o_in_ready stays low until the search has
// finished. The search first clears the vertex record memory (one entry a
// cycle, one entry per active vertex) and then tests each root candidate.
// Each discovered vertex has its record and adjacency row fetched, its
// columns scanned in turn with a record read per edge, is closed and then
// returns to its caller; each member result is popped from the component
// stack and held until the receiver takes it.
// Result transactions leave on o_out_valid/i_out_ready (payload o_out),
// one per vertex, in component completion order; a stalled receiver holds
// the search in its emit step with o_out steady. The user must write
// vertex_count through i_cfg_we/i_cfg_data only while idle; the block
// itself does not enforce this. Reset returns to idle with count 64; the
// adjacency memory is undefined until rows are loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module strongly_connected_components_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  scc_pkg::t_in       i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output scc_pkg::t_out      o_out,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data
);
    localparam int VW = scc_pkg::VW;
    localparam int NW = scc_pkg::NW;

    scc_pkg::t_state r_state, n_state;
    logic [6:0]    r_count;
    logic [NW-1:0] act_n;
    logic [NW-1:0] r_root, n_root;
    logic [NW-1:0] r_clr, n_clr;
    logic [NW-1:0] r_fdepth, n_fdepth;
    logic [NW-1:0] r_cdepth, n_cdepth;
    logic [NW-1:0] r_nout, n_nout;
    logic [6:0]    r_visit, n_visit;
    logic [5:0]    r_comp, n_comp;
    logic [VW-1:0] r_u, n_u;
    logic [NW-1:0] r_next, n_next;
    logic [VW-1:0] r_v, n_v;
    logic [63:0]   r_row, n_row;
    scc_pkg::t_vrec r_urec, n_urec;
    logic [VW-1:0] r_w, n_w;
    scc_pkg::t_out r_pend, n_pend;

    // memories
    logic adj_we; logic [VW-1:0] adj_wa, adj_ra; logic [63:0] adj_wd, adj_rd;
    logic vr_we;  logic [VW-1:0] vr_wa, vr_ra; scc_pkg::t_vrec vr_wd, vr_rd;
    logic cs_we;  logic [VW-1:0] cs_wa, cs_ra; logic [VW-1:0] cs_wd, cs_rd;
    logic fr_we;  logic [VW-1:0] fr_wa, fr_ra;
    logic [VW+NW-1:0] fr_wd, fr_rd;

    scc_ram #(.Width(64), .Depth(scc_pkg::MaxVertices)) u_adj (
        .i_clk, .i_we(adj_we), .i_waddr(adj_wa), .i_wdata(adj_wd),
        .i_raddr(adj_ra), .o_rdata(adj_rd));
    scc_ram #(.Width($bits(scc_pkg::t_vrec)), .Depth(scc_pkg::MaxVertices)) u_vrec (
        .i_clk, .i_we(vr_we), .i_waddr(vr_wa), .i_wdata(vr_wd),
        .i_raddr(vr_ra), .o_rdata(vr_rd));
    scc_ram #(.Width(VW), .Depth(scc_pkg::MaxVertices)) u_cstk (
        .i_clk, .i_we(cs_we), .i_waddr(cs_wa), .i_wdata(cs_wd),
        .i_raddr(cs_ra), .o_rdata(cs_rd));
    scc_ram #(.Width(VW + NW), .Depth(scc_pkg::MaxVertices)) u_frame (
        .i_clk, .i_we(fr_we), .i_waddr(fr_wa), .i_wdata(fr_wd),
        .i_raddr(fr_ra), .o_rdata(fr_rd));

    // saturated vertex count
    always_comb begin
        if (r_count == 7'd0) begin
            act_n = NW'(1);
        end else if (r_count > 7'(scc_pkg::MaxVertices)) begin
            act_n = NW'(scc_pkg::MaxVertices);
        end else begin
            act_n = NW'(r_count);
        end
    end

    assign o_in_ready  = (r_state == scc_pkg::S_IDLE);
    assign o_out_valid = (r_state == scc_pkg::S_EMIT);
    assign o_out       = r_pend;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scc_pkg::S_IDLE:
                if (i_in_valid && i_in.op == scc_pkg::OP_RUN) n_state = scc_pkg::S_CLEAR;
            scc_pkg::S_CLEAR:
                if (r_clr == act_n - NW'(1)) n_state = scc_pkg::S_ROOT;
            scc_pkg::S_ROOT:
                n_state = (r_root == act_n) ? scc_pkg::S_FINISH : scc_pkg::S_ROOT_RD;
            scc_pkg::S_ROOT_RD:
                n_state = (vr_rd.disc == 7'd0) ? scc_pkg::S_ENTER : scc_pkg::S_ROOT;
            scc_pkg::S_ENTER:    n_state = scc_pkg::S_TOP;
            scc_pkg::S_TOP:      n_state = scc_pkg::S_TOP_WAIT;
            scc_pkg::S_TOP_WAIT: n_state = scc_pkg::S_SCAN;
            scc_pkg::S_SCAN:
                if (r_next >= act_n) n_state = scc_pkg::S_CLOSE;
                else if (r_row[r_next[VW-1:0]]) n_state = scc_pkg::S_NB_WAIT;
            scc_pkg::S_NB_WAIT:  n_state = scc_pkg::S_NB;
            scc_pkg::S_NB:
                n_state = (vr_rd.disc == 7'd0) ? scc_pkg::S_ENTER : scc_pkg::S_SCAN;
            scc_pkg::S_CLOSE:
                n_state = (r_urec.disc == r_urec.low && r_cdepth != '0)
                          ? scc_pkg::S_POP_RD : scc_pkg::S_RET;
            scc_pkg::S_POP_RD:   n_state = scc_pkg::S_POP_WAIT;
            scc_pkg::S_POP_WAIT: n_state = scc_pkg::S_POP;
            scc_pkg::S_POP:      n_state = scc_pkg::S_EMIT;
            scc_pkg::S_EMIT:
                if (i_out_ready) begin
                    n_state = r_pend.last_of_component ? scc_pkg::S_RET : scc_pkg::S_POP_RD;
                end
            scc_pkg::S_RET:
                n_state = (r_fdepth == NW'(1)) ? scc_pkg::S_ROOT : scc_pkg::S_PAR_WAIT;
            scc_pkg::S_PAR_WAIT: n_state = scc_pkg::S_PAR;
            scc_pkg::S_PAR:      n_state = scc_pkg::S_SCAN;
            scc_pkg::S_FINISH:   n_state = scc_pkg::S_IDLE;
            default:             n_state = scc_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_root = r_root; n_clr = r_clr; n_fdepth = r_fdepth; n_cdepth = r_cdepth;
        n_visit = r_visit; n_comp = r_comp; n_u = r_u; n_next = r_next; n_v = r_v;
        n_row = r_row; n_urec = r_urec; n_w = r_w; n_nout = r_nout;
        n_pend = r_pend;
        adj_we = 1'b0; adj_wa = i_in.row_index; adj_wd = i_in.row_bits; adj_ra = r_u;
        vr_we = 1'b0; vr_wa = r_v; vr_wd = '0; vr_ra = r_v;
        cs_we = 1'b0; cs_wa = r_cdepth[VW-1:0]; cs_wd = r_v;
        cs_ra = VW'(r_cdepth - NW'(1));
        fr_we = 1'b0; fr_wa = r_fdepth[VW-1:0]; fr_wd = {r_v, NW'(0)};
        fr_ra = VW'(r_fdepth - NW'(1));
        unique case (r_state)
            scc_pkg::S_IDLE: begin
                adj_we = i_in_valid && i_in.op == scc_pkg::OP_LOAD;
                n_clr = '0; n_root = '0; n_fdepth = '0; n_cdepth = '0;
                n_visit = '0; n_comp = '0; n_nout = '0;
            end
            scc_pkg::S_CLEAR: begin
                vr_we = 1'b1; vr_wa = r_clr[VW-1:0];
                n_clr = r_clr + NW'(1);
            end
            scc_pkg::S_ROOT: begin
                vr_ra = r_root[VW-1:0]; n_v = r_root[VW-1:0];
            end
            scc_pkg::S_ROOT_RD: n_root = r_root + NW'(1);
            scc_pkg::S_ENTER: begin
                // discover r_v: number it, push on both stacks
                vr_we = 1'b1; vr_wd = '{disc: r_visit + 7'd1, low: r_visit + 7'd1, onstk: 1'b1};
                n_visit = r_visit + 7'd1;
                cs_we = 1'b1; n_cdepth = r_cdepth + NW'(1);
                // save caller's scan position before pushing
                if (r_fdepth != '0) begin
                    fr_we = 1'b1; fr_wa = VW'(r_fdepth - NW'(1)); fr_wd = {r_u, r_next};
                end
                n_fdepth = r_fdepth + NW'(1);
                n_u = r_v; n_next = '0;
            end
            scc_pkg::S_TOP: begin
                vr_ra = r_u; adj_ra = r_u;
            end
            scc_pkg::S_TOP_WAIT: begin
                n_urec = vr_rd; n_row = adj_rd;
            end
            scc_pkg::S_SCAN: begin
                if (r_next < act_n) begin
                    n_v = r_next[VW-1:0]; vr_ra = r_next[VW-1:0];
                    n_next = r_next + NW'(1);
                end
            end
            scc_pkg::S_NB: begin
                if (vr_rd.onstk && vr_rd.disc != 7'd0 && vr_rd.disc < r_urec.low) begin
                    n_urec.low = vr_rd.disc;
                    vr_we = 1'b1; vr_wa = r_u;
                    vr_wd = '{disc: r_urec.disc, low: vr_rd.disc, onstk: r_urec.onstk};
                end
            end
            scc_pkg::S_CLOSE: ;
            scc_pkg::S_POP_RD: ;
            scc_pkg::S_POP_WAIT: begin
                n_w = cs_rd; vr_ra = cs_rd;
            end
            scc_pkg::S_POP: begin
                // clear on-stack mark of the popped vertex
                n_cdepth = r_cdepth - NW'(1);
                vr_we = 1'b1; vr_wa = r_w;
                vr_wd = '{disc: vr_rd.disc, low: vr_rd.low, onstk: 1'b0};
                if (r_w == r_u) n_urec.onstk = 1'b0;
                // every vertex is emitted once, so the n-th result ends the run
                n_pend = '{vertex: r_w, component_index: r_comp,
                           last_of_component: (r_w == r_u),
                           last_of_run: (r_nout == act_n - NW'(1))};
                n_nout = r_nout + NW'(1);
            end
            scc_pkg::S_EMIT: begin
                if (i_out_ready && r_pend.last_of_component) begin
                    n_comp = r_comp + 6'd1;
                end
            end
            scc_pkg::S_RET: begin
                n_fdepth = r_fdepth - NW'(1);
                fr_ra = VW'(r_fdepth - NW'(2));
            end
            scc_pkg::S_PAR_WAIT: begin
                n_u = fr_rd[VW+NW-1:NW]; n_next = fr_rd[NW-1:0];
                vr_ra = fr_rd[VW+NW-1:NW]; adj_ra = fr_rd[VW+NW-1:NW];
            end
            scc_pkg::S_PAR: begin
                n_row = adj_rd; n_urec = vr_rd;
                if (r_urec.low < vr_rd.low) begin
                    n_urec.low = r_urec.low;
                    vr_we = 1'b1; vr_wa = r_u;
                    vr_wd = '{disc: vr_rd.disc, low: r_urec.low, onstk: vr_rd.onstk};
                end
            end
            scc_pkg::S_FINISH: ;
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::S_IDLE;
            r_count <= 7'd64;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_count <= i_cfg_data;
        end
        r_root <= n_root; r_clr <= n_clr; r_fdepth <= n_fdepth; r_cdepth <= n_cdepth;
        r_visit <= n_visit; r_comp <= n_comp; r_u <= n_u; r_next <= n_next; r_v <= n_v;
        r_row <= n_row; r_urec <= n_urec; r_w <= n_w; r_nout <= n_nout;
        r_pend <= n_pend;
    end

    `ASSERT_HOLDS(a_no_ready_in_run, i_clk, i_rst_n,
        !(o_in_ready && o_out_valid), "input ready while a result is shown")
    `ASSERT_NEXT(a_emit_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out), "stalled result changed")
    `ASSERT_HOLDS(a_depth_range, i_clk, i_rst_n,
        r_fdepth <= NW'(scc_pkg::MaxVertices), "call stack overflow")
endmodule
